// ----- rtl/upd_pkg.sv -----
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character constants and helper functions for the URL
// percent decoder: word formats, the escape phase and the result bundle.
// ----------------------------------------------------------------------------
package upd_pkg;

	// Characters that the decoder recognizes.
	localparam logic [7:0] CHR_PERCENT = 8'h25;
	localparam logic [7:0] CHR_PLUS    = 8'h2B;
	localparam logic [7:0] CHR_SPACE   = 8'h20;
	localparam logic [7:0] CHR_DIGIT0  = 8'h30;
	localparam logic [7:0] CHR_DIGIT9  = 8'h39;
	localparam logic [7:0] CHR_UPPER_A = 8'h41;
	localparam logic [7:0] CHR_UPPER_F = 8'h46;
	localparam logic [7:0] CHR_LOWER_A = 8'h61;
	localparam logic [7:0] CHR_LOWER_F = 8'h66;
	// Letters a-f and A-F carry their value minus nine in the low nibble.
	localparam logic [3:0] HEX_LETTER_OFFSET = 4'd9;

	// Most result words one input word can cause.
	localparam int MAX_RESULTS = 3;

	// Default depth of the queue between front and back.
	localparam int QUEUE_DEPTH_DEF = 2;

	// Input word.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_word_t;

	// Result word.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       out_error;
	} out_word_t;

	// Escape phase: idle, seen a percent sign, seen the sign and one byte.
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	// All results of one input word, handed from front to back.
	// The flags last and err apply to the final result of the bundle only.
	typedef struct packed {
		logic [1:0]                   count;
		logic [MAX_RESULTS-1:0][7:0]  bytes;
		logic                         last;
		logic                         err;
	} bundle_t;

	// Outcome of handling one byte outside a complete escape.
	typedef struct packed {
		phase_t     phase;
		logic       emit;
		logic [7:0] data;
		logic       hold;
	} absorb_t;

	// Value of one hex digit.
	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} hex_t;

	// Decodes one hex digit of either case.
	function automatic hex_t hex_value(logic [7:0] c);
		hex_t r;
		r.ok  = 1'b0;
		r.nib = c[3:0];
		if (c >= CHR_DIGIT0 && c <= CHR_DIGIT9) begin
			r.ok = 1'b1;
		end else if ((c >= CHR_LOWER_A && c <= CHR_LOWER_F) ||
				(c >= CHR_UPPER_A && c <= CHR_UPPER_F)) begin
			r.ok  = 1'b1;
			r.nib = c[3:0] + HEX_LETTER_OFFSET;
		end
		return r;
	endfunction

	// Handles one byte while idle or right after a percent sign.
	function automatic absorb_t absorb(phase_t ph, logic [7:0] b);
		absorb_t r;
		r.phase = PH_IDLE;
		r.emit  = 1'b0;
		r.data  = b;
		r.hold  = 1'b0;
		if (ph == PH_PCT) begin
			r.phase = PH_DIGIT;
			r.hold  = 1'b1;
		end else if (b == CHR_PERCENT) begin
			r.phase = PH_PCT;
		end else if (b == CHR_PLUS) begin
			r.emit = 1'b1;
			r.data = CHR_SPACE;
		end else begin
			r.emit = 1'b1;
		end
		return r;
	endfunction

endpackage

// ----- rtl/upd_stream_if.sv -----
// ----------------------------------------------------------------------------
// upd_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface upd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/upd_front.sv -----
// ----------------------------------------------------------------------------
// upd_front
// Accepts encoded bytes, tracks the escape phase and turns each input word
// into a bundle of zero to three results; one with any results is queued.
// ----------------------------------------------------------------------------
module upd_front
	import upd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	upd_stream_if.sink    din,
	input  logic          full,
	output logic          push,
	output bundle_t       push_data
);

	phase_t     phase_q;
	logic [7:0] held_q;

	logic       accept;
	hex_t       hx_hi;
	hex_t       hx_lo;
	absorb_t    ab_held;
	absorb_t    ab_bad;
	absorb_t    ab_norm;

	logic [1:0]                  walk_n;
	logic [MAX_RESULTS-1:0][7:0] walk_bytes;
	phase_t                      walk_phase;
	logic                        walk_hold;

	phase_t     phase_d;
	logic       err_end;

	// A word is taken whenever the queue has room.
	assign din.ready = !full;
	assign accept    = din.valid && din.ready;

	// Classify the held byte and the new byte.
	assign hx_hi   = hex_value(held_q);
	assign hx_lo   = hex_value(din.data.in_byte);
	assign ab_held = absorb(PH_IDLE, held_q);
	assign ab_bad  = absorb(ab_held.phase, din.data.in_byte);
	assign ab_norm = absorb((phase_q == PH_PCT) ? PH_PCT : PH_IDLE, din.data.in_byte);

	// Collect the results of the word before the end-of-string check.
	always_comb begin
		walk_n     = 2'd0;
		walk_bytes = '0;
		walk_phase = PH_IDLE;
		walk_hold  = 1'b0;
		case (phase_q)
			PH_DIGIT: begin
				if (hx_hi.ok && hx_lo.ok) begin
					walk_bytes[0] = {hx_hi.nib, hx_lo.nib};
					walk_n        = 2'd1;
				end else begin
					// Bad escape: the sign goes out, both bytes are run again.
					walk_bytes[0] = CHR_PERCENT;
					walk_n        = 2'd1;
					if (ab_held.emit) begin
						walk_bytes[1] = ab_held.data;
						walk_n        = 2'd2;
					end
					if (ab_bad.emit) begin
						walk_bytes[walk_n] = ab_bad.data;
						walk_n             = walk_n + 2'd1;
					end
					walk_phase = ab_bad.phase;
					walk_hold  = ab_bad.hold;
				end
			end
			default: begin
				if (ab_norm.emit) begin
					walk_bytes[0] = ab_norm.data;
					walk_n        = 2'd1;
				end
				walk_phase = ab_norm.phase;
				walk_hold  = ab_norm.hold;
			end
		endcase
	end

	// Next escape phase: the end of the string always closes it.
	assign err_end = din.data.in_last && (walk_phase != PH_IDLE);
	always_comb begin
		phase_d = walk_phase;
		if (din.data.in_last) begin
			phase_d = PH_IDLE;
		end
	end

	// Bundle for the back end; a truncated escape adds a zero error word.
	always_comb begin
		push_data.bytes = walk_bytes;
		push_data.count = walk_n;
		push_data.last  = din.data.in_last;
		push_data.err   = err_end;
		if (err_end) begin
			push_data.bytes[walk_n] = 8'h00;
			push_data.count         = walk_n + 2'd1;
		end
		push = accept && (push_data.count != 2'd0);
	end

	// Escape phase register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (accept) begin
			phase_q <= phase_d;
		end
	end

	// Byte held after a percent sign.
	always_ff @(posedge clk) begin
		if (accept && walk_hold) begin
			held_q <= din.data.in_byte;
		end
	end

endmodule

// ----- rtl/upd_queue.sv -----
// ----------------------------------------------------------------------------
// upd_queue
// Short first-in first-out queue of result bundles between front and back.
// ----------------------------------------------------------------------------
module upd_queue
	import upd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	output logic    full,
	input  logic    pop,
	output logic    empty,
	output bundle_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bundle_t            slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/upd_back.sv -----
// ----------------------------------------------------------------------------
// upd_back
// Plays out the bundle at the queue head one result word per cycle into an
// output register, while that register is empty or being read.
// ----------------------------------------------------------------------------
module upd_back
	import upd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  bundle_t       head,
	output logic          pop,
	upd_stream_if.source  dout
);

	logic [1:0] idx_q;
	logic       ovalid_q;
	out_word_t  out_q;

	logic       load;
	logic       take;
	logic       is_end;

	// The output register takes a new word when it is empty or being read.
	assign load   = !ovalid_q || dout.ready;
	assign take   = load && !empty;
	assign is_end = (idx_q == head.count - 2'd1);
	assign pop    = take && is_end;

	assign dout.valid = ovalid_q;
	assign dout.data  = out_q;

	// Position in the head bundle and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= 2'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				ovalid_q <= !empty;
			end
			if (take) begin
				idx_q <= is_end ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (take) begin
			out_q.out_byte  <= head.bytes[idx_q];
			out_q.out_last  <= head.last && is_end;
			out_q.out_error <= head.err && is_end;
		end
	end

endmodule

// ----- rtl/url_percent_decoder.sv -----
// ----------------------------------------------------------------------------
// url_percent_decoder
// Decodes a form-urlencoded byte string: percent escapes, plus as space.
// ----------------------------------------------------------------------------
// Usage: encoded bytes enter on din, one word per handshake, with in_last on
// the final byte of a string. Decoded bytes leave on dout with out_last on
// the final result of the string; out_error with a zero byte marks a string
// that ended inside a percent escape.
// A word that gives results passes through the queue and the output register
// before it appears on dout. The front takes one word per cycle while the
// queue has room; the back end drives one result per cycle from its output
// register while the receiver takes them, so the sustained rate is one word
// per cycle while no word gives more than one; a bad escape, which gives up
// to three results from one word, holds the input once the queue fills.
// Reset clears the escape phase, the queue and the output register; no
// clearing pass is needed and a word can be taken in the first cycle.
// When the receiver stalls the output word holds, the queue fills and din
// ready drops once QUEUE_DEPTH bundles are waiting.
// ----------------------------------------------------------------------------
module url_percent_decoder
	import upd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
	input  logic          clk,
	input  logic          arst_n,
	upd_stream_if.sink    din,
	upd_stream_if.source  dout
);

	logic    push;
	bundle_t push_data;
	logic    full;
	logic    pop;
	logic    empty;
	bundle_t head;

	// Front: accept and classify.
	upd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	// Queue between front and back.
	upd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	// Back: emit result words.
	upd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.dout   (dout)
	);

endmodule

// ----- tb/url_percent_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// url_percent_decoder_tb
// Self-checking bench for the URL percent decoder. A short directed string
// set covers the byte extremes, plus signs, good, bad and cut-short escapes;
// then random strings, mostly well-formed with random content, run with
// random idling on both channels and one long receiver hold-off. A tracker
// class predicts every decoded word and checks each result in order.
// ----------------------------------------------------------------------------
module url_percent_decoder_tb;
	import upd_pkg::*;

	// Cycles with no accepted word on either channel before the run gives up.
	localparam int WATCHDOG_LIMIT = 2000;
	// Length of the long receiver hold-off.
	localparam int HOLD_OFF_CYCLES = 60;
	// Words to send before the stimulus stops.
	localparam int WORD_TARGET = 215;

	// Tracks the escape phase and holds the decoded words still to come.
	class pct_decode_tracker;
		phase_t     phase;
		logic [7:0] held_byte;
		out_word_t  step_q[$];
		out_word_t  decoded_q[$];
		int         mismatches;

		function new();
			phase      = PH_IDLE;
			held_byte  = 8'h00;
			mismatches = 0;
		endfunction

		// Returns 1 and the nibble value when c is a hex digit of either case.
		function bit hex_nib(logic [7:0] c, output logic [3:0] v);
			v = 4'h0;
			if (c >= CHR_DIGIT0 && c <= CHR_DIGIT9) begin
				v = 4'(c - CHR_DIGIT0);
				return 1'b1;
			end
			if (c >= CHR_LOWER_A && c <= CHR_LOWER_F) begin
				v = 4'(c - CHR_LOWER_A + 8'd10);
				return 1'b1;
			end
			if (c >= CHR_UPPER_A && c <= CHR_UPPER_F) begin
				v = 4'(c - CHR_UPPER_A + 8'd10);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void emit(logic [7:0] b);
			step_q.push_back('{out_byte: b, out_last: 1'b0, out_error: 1'b0});
		endfunction

		// Handles one byte while idle or right after a percent sign.
		function void absorb_byte(logic [7:0] b);
			if (phase == PH_PCT) begin
				held_byte = b;
				phase     = PH_DIGIT;
				return;
			end
			phase = PH_IDLE;
			if (b == CHR_PERCENT)
				phase = PH_PCT;
			else if (b == CHR_PLUS)
				emit(CHR_SPACE);
			else
				emit(b);
		endfunction

		// Works out the decoded words caused by one accepted input word.
		function void note_word(in_word_t w);
			logic [3:0] hi, lo;
			logic [7:0] first;
			bit         hi_ok, lo_ok;
			step_q.delete();
			if (phase == PH_DIGIT) begin
				hi_ok = hex_nib(held_byte, hi);
				lo_ok = hex_nib(w.in_byte, lo);
				phase = PH_IDLE;
				if (hi_ok && lo_ok) begin
					emit({hi, lo});
				end else begin
					// Bad escape: the sign goes out, both bytes are decoded again.
					first = held_byte;
					emit(CHR_PERCENT);
					absorb_byte(first);
					absorb_byte(w.in_byte);
				end
			end else begin
				absorb_byte(w.in_byte);
			end
			if (w.in_last) begin
				if (phase != PH_IDLE) begin
					// The string ended inside an escape.
					phase = PH_IDLE;
					step_q.push_back('{out_byte: 8'h00, out_last: 1'b1, out_error: 1'b1});
				end else if (step_q.size() > 0) begin
					step_q[step_q.size()-1].out_last = 1'b1;
				end
			end
			foreach (step_q[i])
				decoded_q.push_back(step_q[i]);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		// Compares one result word with the oldest expected word.
		task check_result(out_word_t got);
			out_word_t want;
			if (decoded_q.size() == 0) begin
				report($sformatf("unexpected word byte %02h last %0b error %0b",
					got.out_byte, got.out_last, got.out_error));
				return;
			end
			want = decoded_q.pop_front();
			if (got.out_byte !== want.out_byte)
				report($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
			if (got.out_last !== want.out_last)
				report($sformatf("out_last %0b, expected %0b", got.out_last, want.out_last));
			if (got.out_error !== want.out_error)
				report($sformatf("out_error %0b, expected %0b", got.out_error, want.out_error));
		endtask

		function int pending();
			return decoded_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	upd_stream_if #(.payload_t(in_word_t))  din_if ();
	upd_stream_if #(.payload_t(out_word_t)) dout_if ();

	url_percent_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	pct_decode_tracker tracker = new();

	bit idle_on = 1'b1;
	bit hold_off_req = 1'b0;
	bit hold_off_done = 1'b0;
	int words_sent = 0;
	int quiet_cycles = 0;

	always #10 clk = ~clk;

	// Monitor: note accepted input words, check accepted result words.
	always @(posedge clk) begin
		if (din_if.valid === 1'b1 && din_if.ready === 1'b1)
			tracker.note_word(din_if.data);
		if (dout_if.valid === 1'b1 && dout_if.ready === 1'b1)
			tracker.check_result(dout_if.data);
		if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no word accepted for %0d cycles", $realtime, quiet_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: random stalls, and one long hold-off when asked.
	initial begin
		dout_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				dout_if.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				dout_if.ready <= (!idle_on || $urandom_range(0, 99) >= 33);
			end
		end
	end

	// Offers one word after random idle cycles and waits until it is taken.
	task automatic send_word(logic [7:0] b, logic last);
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < 33) begin
			din_if.valid <= 1'b0;
			@(negedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.data  <= '{in_byte: b, in_last: last};
		do
			@(posedge clk);
		while (din_if.ready !== 1'b1);
		words_sent++;
	endtask

	// Sends a text string, the final character marked last when asked.
	task automatic send_text(string s, logic last);
		int i;
		for (i = 0; i < s.len(); i++)
			send_word(s[i], last && (i == s.len() - 1));
	endtask

	function automatic logic [7:0] rand_hex();
		int k;
		k = $urandom_range(0, 21);
		if (k < 10)
			return 8'(CHR_DIGIT0 + k);
		if (k < 16)
			return 8'(CHR_LOWER_A + k - 10);
		return 8'(CHR_UPPER_A + k - 16);
	endfunction

	function automatic logic [7:0] rand_non_hex();
		logic [7:0] b;
		logic [3:0] v;
		do
			b = 8'($urandom_range(0, 255));
		while (tracker.hex_nib(b, v));
		return b;
	endfunction

	// Builds one random string out of tokens and sends it.
	task automatic send_random_string();
		logic [7:0] s[$];
		logic [7:0] a, b;
		logic [3:0] va, vb;
		int         n, kind, i;
		n = $urandom_range(1, 6);
		for (i = 0; i < n; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				s.push_back(CHR_PERCENT);
				s.push_back(rand_hex());
				s.push_back(rand_hex());
			end else if (kind < 50) begin
				s.push_back(8'($urandom_range(8'h20, 8'h7E)));
			end else if (kind < 58) begin
				s.push_back(CHR_PLUS);
			end else if (kind < 73) begin
				s.push_back(8'($urandom_range(0, 255)));
			end else if (kind < 90) begin
				// Bad escape; either byte may be a sign of its own.
				a = ($urandom_range(0, 3) == 0) ? CHR_PERCENT : 8'($urandom_range(0, 255));
				b = ($urandom_range(0, 3) == 0) ? CHR_PLUS : 8'($urandom_range(0, 255));
				if (tracker.hex_nib(a, va) && tracker.hex_nib(b, vb))
					b = rand_non_hex();
				s.push_back(CHR_PERCENT);
				s.push_back(a);
				s.push_back(b);
			end else begin
				s.push_back(CHR_PERCENT);
			end
		end
		// Now and then the string stops inside an escape.
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			s.push_back(CHR_PERCENT);
		end else if (kind == 1) begin
			s.push_back(CHR_PERCENT);
			s.push_back(rand_hex());
		end
		foreach (s[j])
			send_word(s[j], j == s.size() - 1);
	endtask

	// Main sequence: reset, directed strings, random strings, drain.
	initial begin
		arst_n       = 1'b0;
		din_if.valid = 1'b0;
		din_if.data  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: byte extremes, plus, escapes of both cases, bad and cut-short ones.
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_text("+%4a%Ff", 1'b1);
		send_text("%G1%2%41", 1'b1);
		send_text("%", 1'b1);
		send_text("%7", 1'b1);
		send_text("x", 1'b1);
		send_text("%+Z", 1'b1);

		// Random strings, with a stretch of no idling and one long hold-off.
		while (words_sent < WORD_TARGET) begin
			idle_on = !(words_sent >= 130 && words_sent < 180);
			if (words_sent >= 70 && !hold_off_done) begin
				hold_off_req  = 1'b1;
				hold_off_done = 1'b1;
			end
			send_random_string();
		end
		@(negedge clk);
		din_if.valid <= 1'b0;
		idle_on = 1'b1;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/upd_pkg.sv
rtl/upd_stream_if.sv
rtl/upd_front.sv
rtl/upd_queue.sv
rtl/upd_back.sv
rtl/url_percent_decoder.sv
tb/url_percent_decoder_tb.sv
